/* sv/assert_macros.svh */
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/egas_pkg.sv */
package egas_pkg;

    localparam int CNT_MAX_W = 17;
    localparam int IDX_MAX_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [15:0] EPS_RESET   = 16'd65535;
    localparam logic [15:0] DECAY_RESET = 16'd65208;
    localparam logic [15:0] FLOOR_RESET = 16'd655;
    localparam logic [31:0] SEED_RESET  = 32'd12345;

    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    typedef enum logic [1:0] {
        CFG_EPS_START = 2'd0,
        CFG_DECAY     = 2'd1,
        CFG_FLOOR     = 2'd2,
        CFG_SEED      = 2'd3
    } t_cfg_idx;

    // work handed from the front to the back
    typedef struct packed {
        logic                 is_decay;
        logic [CNT_MAX_W-1:0] count;
        logic [IDX_MAX_W-1:0] best;
    } t_cmd;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << XS_A);
        b = a ^ (a >> XS_B);
        return b ^ (b << XS_C);
    endfunction

endpackage

/* sv/egas_front.sv */
module egas_front #(
    parameter int MAX_ACTIONS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic signed [31:0] i_conf,
    input  logic               i_last,
    input  logic               i_full,
    output logic               o_push,
    output egas_pkg::t_cmd     o_cmd
);

    localparam int CW = $clog2(MAX_ACTIONS + 1);
    localparam int IW = $clog2(MAX_ACTIONS);

    logic signed [31:0] r_top_conf, n_top_conf;
    logic [IW-1:0]      r_best_idx,  n_best_idx;
    logic [CW-1:0]      r_count,     n_count;

    logic          accept;
    logic          room;
    logic          take;
    logic [IW-1:0] best_after;
    logic [CW-1:0] count_after;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign room    = r_count < CW'(MAX_ACTIONS);
    // first element of a set wins unconditionally, later ones only if strictly greater
    assign take    = room && ((r_count == '0) || (i_conf > r_top_conf));

    always_comb begin
        best_after  = take ? r_count[IW-1:0] : r_best_idx;
        count_after = room ? r_count + CW'(1) : r_count;

        n_top_conf = r_top_conf;
        n_best_idx  = r_best_idx;
        n_count     = r_count;
        o_push      = 1'b0;
        o_cmd       = '0;

        if (accept) begin
            if (i_func) begin
                o_push       = 1'b1;
                o_cmd.is_decay = 1'b1;
            end else if (i_last) begin
                o_push    = 1'b1;
                o_cmd.count = egas_pkg::CNT_MAX_W'(count_after);
                o_cmd.best  = egas_pkg::IDX_MAX_W'(best_after);
                n_top_conf = '0;
                n_best_idx  = '0;
                n_count     = '0;
            end else begin
                if (take) begin
                    n_top_conf = i_conf;
                end
                n_best_idx = best_after;
                n_count    = count_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_conf <= '0;
            r_best_idx  <= '0;
            r_count     <= '0;
        end else begin
            r_top_conf <= n_top_conf;
            r_best_idx  <= n_best_idx;
            r_count     <= n_count;
        end
    end

endmodule

/* sv/egas_fifo.sv */
module egas_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  egas_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output egas_pkg::t_cmd o_data,
    output logic           o_empty
);

    egas_pkg::t_cmd r_mem [egas_pkg::FIFO_DEPTH];

    logic [egas_pkg::FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [egas_pkg::FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [egas_pkg::FIFO_CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == egas_pkg::FIFO_CNT_W'(egas_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + egas_pkg::FIFO_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + egas_pkg::FIFO_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + egas_pkg::FIFO_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - egas_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/egas_back.sv */
module egas_back #(
    parameter int MAX_ACTIONS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_cmd_valid,
    input  egas_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_index,
    output logic           o_explored,
    output logic [15:0]    o_eps
);

    localparam int CW = $clog2(MAX_ACTIONS + 1);
    localparam int IW = $clog2(MAX_ACTIONS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DECAY = 4'b0010,
        S_DIV   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [15:0]   r_eps,   n_eps;
    logic [31:0]   r_rng,   n_rng;
    logic [15:0]   r_decay, n_decay;
    logic [15:0]   r_floor, n_floor;
    logic [31:0]   r_prod,  n_prod;
    logic [31:0]   r_dvd,   n_dvd;
    logic [CW-1:0] r_rem,   n_rem;
    logic [CW-1:0] r_div,   n_div;
    logic [4:0]    r_step,  n_step;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_idx,   n_out_idx;
    logic          r_out_exp,   n_out_exp;
    logic [15:0]   r_out_eps,   n_out_eps;

    logic          out_free;
    logic [31:0]   draw1;
    logic [31:0]   draw2;
    logic [CW:0]   trial;
    logic          fits;
    logic [15:0]   decayed;
    logic [31:0]   best_wide;
    logic [31:0]   rem_wide;
    logic [IW-1:0] cmd_best;

    assign out_free  = !r_out_valid || i_ready;
    assign draw1     = egas_pkg::xorshift(r_rng);
    assign draw2     = egas_pkg::xorshift(draw1);
    // restoring remainder, one dividend bit per cycle
    assign trial     = {r_rem, r_dvd[31]};
    assign fits      = trial >= {1'b0, r_div};
    assign decayed   = r_prod[31:16];
    assign cmd_best  = i_cmd.best[IW-1:0];
    assign best_wide = 32'(cmd_best);
    assign rem_wide  = 32'(r_rem);

    assign o_valid    = r_out_valid;
    assign o_index    = r_out_idx;
    assign o_explored = r_out_exp;
    assign o_eps      = r_out_eps;

    always_comb begin
        n_state     = r_state;
        n_eps       = r_eps;
        n_rng       = r_rng;
        n_decay     = r_decay;
        n_floor     = r_floor;
        n_prod      = r_prod;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_div       = r_div;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        n_out_idx   = r_out_idx;
        n_out_exp   = r_out_exp;
        n_out_eps   = r_out_eps;
        o_cmd_pop   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (i_cmd.is_decay || out_free)) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_decay) begin
                        if (r_eps > r_floor) begin
                            n_prod  = {16'd0, r_eps} * {16'd0, r_decay};
                            n_state = S_DECAY;
                        end
                    end else if (draw1[15:0] < r_eps) begin
                        n_rng   = draw2;
                        n_dvd   = draw2;
                        n_rem   = '0;
                        n_div   = i_cmd.count[CW-1:0];
                        n_step  = 5'd31;
                        n_state = S_DIV;
                    end else begin
                        n_rng       = draw1;
                        n_out_valid = 1'b1;
                        n_out_idx   = best_wide[7:0];
                        n_out_exp   = 1'b0;
                        n_out_eps   = r_eps;
                    end
                end
            end
            S_DECAY: begin
                n_eps   = (decayed < r_floor) ? r_floor : decayed;
                n_state = S_IDLE;
            end
            S_DIV: begin
                n_rem  = fits ? CW'(trial - {1'b0, r_div}) : CW'(trial);
                n_dvd  = {r_dvd[30:0], 1'b0};
                n_step = r_step - 5'd1;
                if (r_step == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = rem_wide[7:0];
                    n_out_exp   = 1'b1;
                    n_out_eps   = r_eps;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (egas_pkg::t_cfg_idx'(i_cfg_idx))
                egas_pkg::CFG_EPS_START: n_eps   = i_cfg_data[15:0];
                egas_pkg::CFG_DECAY:     n_decay = i_cfg_data[15:0];
                egas_pkg::CFG_FLOOR:     n_floor = i_cfg_data[15:0];
                egas_pkg::CFG_SEED:      n_rng   = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eps       <= egas_pkg::EPS_RESET;
            r_rng       <= egas_pkg::SEED_RESET;
            r_decay     <= egas_pkg::DECAY_RESET;
            r_floor     <= egas_pkg::FLOOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eps       <= n_eps;
            r_rng       <= n_rng;
            r_decay     <= n_decay;
            r_floor     <= n_floor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_step    <= n_step;
        r_out_idx <= n_out_idx;
        r_out_exp <= n_out_exp;
        r_out_eps <= n_out_eps;
    end

endmodule

/* sv/epsilon_greedy_action_selector.sv */
// confidences are taken one word per cycle; a full four-entry command queue stalls input
// greedy decision: queued, then registered; one per cycle while the output is ready
// explored decision: computed by the bit-serial 32-step modulo unit
// decay tick: in the back end, a registered 16x16 multiply, then clamp
// synchronous active-low reset: empty queue, empty set, config and state registers at their defaults
`include "assert_macros.svh"

module epsilon_greedy_action_selector #(
    parameter int MAX_ACTIONS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic signed [31:0] i_s_axis_tdata,   // [31:0] confidence
    input  logic               i_s_axis_tuser,   // [0] func
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,   // [7:0] action_index, [23:8] epsilon_now
    output logic               o_m_axis_tuser,   // [0] explored
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    egas_pkg::t_cmd push_cmd;
    egas_pkg::t_cmd head_cmd;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic [7:0]     out_idx;
    logic [15:0]    out_eps;

    egas_front #(
        .MAX_ACTIONS(MAX_ACTIONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser),
        .i_conf  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    egas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    egas_back #(
        .MAX_ACTIONS(MAX_ACTIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!q_empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_index     (out_idx),
        .o_explored  (o_m_axis_tuser),
        .o_eps       (out_eps)
    );

    assign o_m_axis_tdata = {out_eps, out_idx};

    `ASSERT_CLK(a_no_push_when_full, i_clk, i_rst_n, !(q_push && q_full))
    `ASSERT_CLK(a_no_pop_when_empty, i_clk, i_rst_n, !(q_pop && q_empty))
    `ASSERT_NEXT(a_pop_then_room, i_clk, i_rst_n, q_pop && !q_push, !q_full)

endmodule

/* bench/testbench.sv */
module testbench;

    localparam int MAX_ACT       = 256;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [7:0]  action;
        logic        explored;
        logic [15:0] eps;
    } t_decision;

    // running model of the selector: argmax, xorshift draws, epsilon decay
    class selection_scoreboard;
        logic [15:0]        decay_q;
        logic [15:0]        floor_q;
        logic [31:0]        rng;
        logic [15:0]        eps;
        logic signed [31:0] top_conf;
        logic [7:0]         best_idx;
        int unsigned        set_len;
        t_decision          decisions_q[$];
        int                 failures;
        int                 reported;

        function new();
            decay_q   = 16'd65208;
            floor_q   = 16'd655;
            rng       = 32'd12345;
            eps       = 16'd65535;
            top_conf = '0;
            best_idx  = '0;
            set_len   = 0;
            failures  = 0;
            reported  = 0;
        endfunction

        function logic [31:0] draw();
            logic [31:0] x;
            x   = rng;
            x   = x ^ (x << 13);
            x   = x ^ (x >> 17);
            x   = x ^ (x << 5);
            rng = x;
            return x;
        endfunction

        function void load_reg(egas_pkg::t_cfg_idx idx, logic [31:0] data);
            case (idx)
                egas_pkg::CFG_EPS_START: eps     = data[15:0];
                egas_pkg::CFG_DECAY:     decay_q = data[15:0];
                egas_pkg::CFG_FLOOR:     floor_q = data[15:0];
                egas_pkg::CFG_SEED:      rng     = data;
                default: begin
                end
            endcase
        endfunction

        function void note_word(logic func, logic signed [31:0] conf, logic last);
            logic [31:0] prod;
            logic [31:0] r;
            t_decision   d;
            if (func) begin
                if (eps > floor_q) begin
                    prod = ({16'd0, eps} * {16'd0, decay_q}) >> 16;
                    if (prod < {16'd0, floor_q})
                        prod = {16'd0, floor_q};
                    eps = prod[15:0];
                end
                return;
            end
            if (set_len < MAX_ACT) begin
                if (set_len == 0 || conf > top_conf) begin
                    top_conf = conf;
                    best_idx  = set_len[7:0];
                end
                set_len++;
            end
            if (!last)
                return;
            r = draw();
            if (r[15:0] < eps) begin
                r          = draw();
                d.action   = 8'(r % set_len);
                d.explored = 1'b1;
            end else begin
                d.action   = best_idx;
                d.explored = 1'b0;
            end
            d.eps = eps;
            decisions_q.push_back(d);
            set_len   = 0;
            best_idx  = '0;
            top_conf = '0;
        endfunction

        function void check_result(logic [7:0] action, logic explored, logic [15:0] eps_seen);
            t_decision want;
            if (decisions_q.size() == 0) begin
                failures++;
                if (reported < 10)
                    $display("unexpected decision: action %0d explored %0b eps %0d",
                             action, explored, eps_seen);
                reported++;
                return;
            end
            want = decisions_q.pop_front();
            if (want.action !== action || want.explored !== explored ||
                want.eps !== eps_seen) begin
                failures++;
                if (reported < 10)
                    $display("decision mismatch: expected action %0d explored %0b eps %0d,",
                             want.action, want.explored, want.eps,
                             " got action %0d explored %0b eps %0d",
                             action, explored, eps_seen);
                reported++;
            end
        endfunction

        function int pending();
            return decisions_q.size();
        endfunction
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic signed [31:0] i_s_axis_tdata  = '0;
    logic               i_s_axis_tuser  = 1'b0;
    logic               i_s_axis_tlast  = 1'b0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [23:0]        o_m_axis_tdata;
    logic               o_m_axis_tuser;
    logic               i_cfg_we        = 1'b0;
    logic [1:0]         i_cfg_idx       = '0;
    logic [31:0]        i_cfg_data      = '0;

    selection_scoreboard sb = new();
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold    = 0;
    int words_sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    epsilon_greedy_action_selector #(
        .MAX_ACTIONS(MAX_ACT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    task automatic send_word(input logic func, input logic [31:0] conf, input logic last);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= func;
        i_s_axis_tdata  <= conf;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_word(func, conf, last);
        words_sent++;
    endtask

    // extremes, near-ties around a per-set base, and random values
    function automatic logic [31:0] pick_conf(input logic [31:0] base);
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return base + $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_set(input int len);
        logic [31:0] base;
        base = $urandom();
        for (int k = 0; k < len; k++) begin
            // decay ticks dropped into an open set must not disturb it
            if ($urandom_range(0, 9) == 0)
                send_word(1'b1, $urandom(), 1'($urandom_range(0, 1)));
            send_word(1'b0, pick_conf(base), k == len - 1);
        end
    endtask

    task automatic write_reg(input egas_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.load_reg(idx, data);
    endtask

    // wait out every decision, then the decay pipe and the modulo unit
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata[7:0], o_m_axis_tuser, o_m_axis_tdata[23:8]);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] eps_pick;
        logic [15:0] decay_pick;
        logic [15:0] floor_pick;
        logic [31:0] seed_pick;
        int          phase_start;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // greedy only: ties, extremes, one-word set, tick inside a set
        write_reg(egas_pkg::CFG_EPS_START, 32'h0000_0000);
        send_word(1'b0, 32'h8000_0000, 1'b0);
        send_word(1'b0, 32'h7FFF_FFFF, 1'b0);
        send_word(1'b0, 32'h7FFF_FFFF, 1'b0);
        send_word(1'b0, 32'h0000_0005, 1'b1);
        send_word(1'b0, 32'h8000_0000, 1'b1);
        send_word(1'b0, -32'sd5, 1'b0);
        send_word(1'b0, -32'sd5, 1'b0);
        send_word(1'b1, 32'hFFFF_FFFF, 1'b1);
        send_word(1'b0, -32'sd5, 1'b1);
        settle_block();

        // upper bits must be dropped; a zero seed pins every draw at zero
        write_reg(egas_pkg::CFG_EPS_START, 32'hA5A5_FFFF);
        write_reg(egas_pkg::CFG_FLOOR, 32'hFFFF_0000);
        write_reg(egas_pkg::CFG_DECAY, 32'h0000_8000);
        write_reg(egas_pkg::CFG_SEED, 32'h0000_0000);
        send_word(1'b0, 32'h0000_0007, 1'b0);
        send_word(1'b0, 32'h0000_0003, 1'b1);
        send_word(1'b1, 32'h0000_0000, 1'b0);
        send_word(1'b1, 32'h0000_0000, 1'b0);
        send_word(1'b0, 32'h0000_0001, 1'b1);
        settle_block();
        write_reg(egas_pkg::CFG_SEED, 32'hFFFF_FFFF);
        send_word(1'b0, 32'h0000_0000, 1'b0);
        send_word(1'b0, 32'h0000_0001, 1'b0);
        send_word(1'b0, 32'h0000_0002, 1'b1);

        for (int p = 0; p < 10; p++) begin
            settle_block();
            tx_idle_on = (p < 8) && (p != 5);
            rx_idle_on = tx_idle_on;
            case (p % 4)
                0:       eps_pick = 16'd0;
                1:       eps_pick = 16'd65535;
                2:       eps_pick = 16'($urandom());
                default: eps_pick = 16'($urandom_range(0, 2000));
            endcase
            case ((p + 1) % 4)
                0:       decay_pick = 16'd0;
                1:       decay_pick = 16'd65535;
                2:       decay_pick = 16'($urandom());
                default: decay_pick = 16'd65208;
            endcase
            case ((p + 2) % 4)
                0:       floor_pick = 16'd0;
                1:       floor_pick = 16'd65535;
                2:       floor_pick = 16'($urandom());
                default: floor_pick = 16'($urandom_range(0, 1000));
            endcase
            seed_pick = $urandom();
            if (seed_pick == 0)
                seed_pick = 32'd1;
            write_reg(egas_pkg::CFG_DECAY, {16'($urandom()), decay_pick});
            write_reg(egas_pkg::CFG_FLOOR, {16'($urandom()), floor_pick});
            write_reg(egas_pkg::CFG_SEED, seed_pick);
            write_reg(egas_pkg::CFG_EPS_START, {16'($urandom()), eps_pick});

            // output held off long enough for the command queue to back up
            if (p == 2)
                rx_hold = 150;
            // set longer than the action limit
            if (p == 4)
                send_set(MAX_ACT + 4);

            phase_start = words_sent;
            while (words_sent - phase_start < 25) begin
                if ($urandom_range(0, 7) == 0)
                    send_word(1'b1, $urandom(), 1'($urandom_range(0, 1)));
                else if ($urandom_range(0, 5) == 0)
                    send_set($urandom_range(9, 40));
                else
                    send_set($urandom_range(1, 8));
            end
        end

        settle_block();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
